>>> hdl/rmq_pkg.sv
// Shared widths and types for the rotation-matrix-to-quaternion pipeline.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IW        = 16;
  // clamped trace combination; the factor of four cancels in normalization
  localparam int UW        = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int TW        = UW + 1;
  // per-component root: radicand is u << FRAC_BITS
  localparam int SW1       = (UW + FRAC_BITS + 1) / 2;
  localparam int RW1       = 2 * SW1;
  // norm root: radicand is the sum of four squares
  localparam int SW2       = SW1 + 1;
  localparam int SMW       = 2 * SW2;
  // quotient and dividend of the normalizing divide
  localparam int QW        = FRAC_BITS + 1;
  localparam int NNW       = SW1 + FRAC_BITS + 1;
  localparam int VW        = ((FRAC_BITS + 2) > IW) ? (FRAC_BITS + 2) : IW;
  localparam int LANES     = 4;

  typedef logic [UW-1:0]  rmq_u_t;
  typedef logic [SW1-1:0] rmq_s_t;
  typedef logic [IW-1:0]  rmq_q_t;

  // control that travels with each item
  typedef struct packed {
    logic       valid;
    logic [3:0] neg;
  } rmq_tag_t;

endpackage

>>> hdl/rmq_root4.sv
// Four-lane pipelined square root, one result bit per stage.
`timescale 1ns / 1ps
module rmq_root4 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  rmq_pkg::rmq_tag_t tag_i,
  input  rmq_pkg::rmq_u_t   u_i [4],
  output rmq_pkg::rmq_tag_t tag_o,
  output rmq_pkg::rmq_s_t   s_o [4]
);
  import rmq_pkg::*;

  rmq_tag_t         tag_r  [SW1+1];
  logic [RW1-1:0]   rad_r  [SW1+1][LANES];
  logic [SW1+1:0]   rem_r  [SW1+1][LANES];
  logic [SW1-1:0]   root_r [SW1+1][LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rad_r[0][l]  <= RW1'(u_i[l]) << FRAC_BITS;
        rem_r[0][l]  <= '0;
        root_r[0][l] <= '0;
      end
    end
  end

  for (genvar j = 0; j < SW1; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[j+1] <= '0;
      end else if (en) begin
        tag_r[j+1] <= tag_r[j];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [SW1+3:0] r2;
      logic [SW1+3:0] tr;
      logic [SW1+1:0] rem_nxt;
      logic [SW1-1:0] root_nxt;

      always_comb begin
        r2 = {rem_r[j][l], rad_r[j][l][RW1-1 -: 2]};
        tr = {2'b00, root_r[j][l], 2'b01};
        if (r2 >= tr) begin
          rem_nxt  = (SW1+2)'(r2 - tr);
          root_nxt = {root_r[j][l][SW1-2:0], 1'b1};
        end else begin
          rem_nxt  = r2[SW1+1:0];
          root_nxt = {root_r[j][l][SW1-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[j+1][l]  <= rad_r[j][l] << 2;
          rem_r[j+1][l]  <= rem_nxt;
          root_r[j+1][l] <= root_nxt;
        end
      end
    end
  end

  assign tag_o = tag_r[SW1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign s_o[l] = root_r[SW1][l];
  end

endmodule

>>> hdl/rmq_norm_div.sv
// Norm of the four roots, then a pipelined divide of each root by it.
`timescale 1ns / 1ps
module rmq_norm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  rmq_pkg::rmq_tag_t tag_i,
  input  rmq_pkg::rmq_s_t   s_i [4],
  output logic              valid_o,
  output rmq_pkg::rmq_q_t   q_o [4]
);
  import rmq_pkg::*;

  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  // squares
  rmq_tag_t          sq_tag_r;
  rmq_s_t            sq_s_r [LANES];
  logic [2*SW1-1:0]  sq_r   [LANES];

  // norm root stages, index 0 holds the sum
  rmq_tag_t          nt_r    [SW2+1];
  rmq_s_t            ns_r    [SW2+1][LANES];
  logic [SMW-1:0]    nrad_r  [SW2+1];
  logic [SW2+1:0]    nrem_r  [SW2+1];
  logic [SW2-1:0]    nroot_r [SW2+1];

  // divide stages, index 0 holds the prepared dividend
  rmq_tag_t          dt_r  [QW+1];
  logic              dz_r  [QW+1];
  logic [SW2-1:0]    dn_r  [QW+1];
  logic [SW2-1:0]    drem_r[QW+1][LANES];
  logic [QW-1:0]     dlo_r [QW+1][LANES];
  logic [QW-1:0]     dq_r  [QW+1][LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_tag_r <= '0;
      nt_r[0]  <= '0;
    end else if (en) begin
      sq_tag_r <= tag_i;
      nt_r[0]  <= sq_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        sq_s_r[l]   <= s_i[l];
        sq_r[l]     <= s_i[l] * s_i[l];
        ns_r[0][l]  <= sq_s_r[l];
      end
      nrad_r[0]  <= SMW'(sq_r[0]) + SMW'(sq_r[1]) + SMW'(sq_r[2]) + SMW'(sq_r[3]);
      nrem_r[0]  <= '0;
      nroot_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < SW2; j++) begin : g_nstage
    logic [SW2+3:0] r2;
    logic [SW2+3:0] tr;
    logic [SW2+1:0] rem_nxt;
    logic [SW2-1:0] root_nxt;

    always_comb begin
      r2 = {nrem_r[j], nrad_r[j][SMW-1 -: 2]};
      tr = {2'b00, nroot_r[j], 2'b01};
      if (r2 >= tr) begin
        rem_nxt  = (SW2+2)'(r2 - tr);
        root_nxt = {nroot_r[j][SW2-2:0], 1'b1};
      end else begin
        rem_nxt  = r2[SW2+1:0];
        root_nxt = {nroot_r[j][SW2-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nt_r[j+1] <= '0;
      end else if (en) begin
        nt_r[j+1] <= nt_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nrad_r[j+1]  <= nrad_r[j] << 2;
        nrem_r[j+1]  <= rem_nxt;
        nroot_r[j+1] <= root_nxt;
        for (int l = 0; l < LANES; l++) begin
          ns_r[j+1][l] <= ns_r[j][l];
        end
      end
    end
  end

  // dividend: (s << FRAC_BITS) + n/2, top part seeds the remainder
  logic [SW2-1:0] norm;
  logic [NNW-1:0] dvd [LANES];

  assign norm = nroot_r[SW2];
  for (genvar l = 0; l < LANES; l++) begin : g_dvd
    assign dvd[l] = (NNW'(ns_r[SW2][l]) << FRAC_BITS) + NNW'(norm >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r[0] <= '0;
    end else if (en) begin
      dt_r[0] <= nt_r[SW2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz_r[0] <= (norm == '0);
      dn_r[0] <= norm;
      for (int l = 0; l < LANES; l++) begin
        drem_r[0][l] <= SW2'(dvd[l][NNW-1:QW]);
        dlo_r[0][l]  <= dvd[l][QW-1:0];
        dq_r[0][l]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_dstage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dt_r[k+1] <= '0;
      end else if (en) begin
        dt_r[k+1] <= dt_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dz_r[k+1] <= dz_r[k];
        dn_r[k+1] <= dn_r[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [SW2:0]   r2;
      logic [SW2-1:0] rem_nxt;
      logic [QW-1:0]  q_nxt;

      always_comb begin
        r2 = {drem_r[k][l], dlo_r[k][l][QW-1]};
        if (r2 >= {1'b0, dn_r[k]}) begin
          rem_nxt = SW2'(r2 - {1'b0, dn_r[k]});
          q_nxt   = {dq_r[k][l][QW-2:0], 1'b1};
        end else begin
          rem_nxt = r2[SW2-1:0];
          q_nxt   = {dq_r[k][l][QW-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          drem_r[k+1][l] <= rem_nxt;
          dlo_r[k+1][l]  <= dlo_r[k][l] << 1;
          dq_r[k+1][l]   <= q_nxt;
        end
      end
    end
  end

  // cap at one (norm 0: w=1, rest 0), apply sign, keep low field bits
  assign valid_o = dt_r[QW].valid;
  for (genvar l = 0; l < LANES; l++) begin : g_fmt
    logic [QW-1:0] qc;
    logic [VW-1:0] qx;
    logic [VW-1:0] v;

    always_comb begin
      if (dz_r[QW]) begin
        qc = (l == 0) ? ONE_Q : '0;
      end else if (dq_r[QW][l] > ONE_Q) begin
        qc = ONE_Q;
      end else begin
        qc = dq_r[QW][l];
      end
      qx = VW'(qc);
      v  = dt_r[QW].neg[l] ? (~qx + VW'(1)) : qx;
    end

    assign q_o[l] = v[IW-1:0];
  end

endmodule

>>> hdl/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix in, unit quaternion out, fully pipelined.
//
//   channel | ports                      | direction
//   --------+----------------------------+----------
//   in      | in_valid/in_stall, in_mRC  | matrix in
//   out     | out_valid/out_stall, out_quat_* | quaternion out
//
// One item per cycle unless stalled. Stages: one front stage, the four-lane
// component root (SW1+1 stages), squares and norm root (SW2+2 stages), the
// dividend stage, the divide (FRAC_BITS+1 stages) and the output register.
// rst_n clears the valid bits and item tags, not the data. When the output
// stalls, one more item lands in a skid register, then in_stall rises and
// the whole pipeline holds until the skid register drains.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_m00,
  input  logic signed [15:0]  in_m01,
  input  logic signed [15:0]  in_m02,
  input  logic signed [15:0]  in_m10,
  input  logic signed [15:0]  in_m11,
  input  logic signed [15:0]  in_m12,
  input  logic signed [15:0]  in_m20,
  input  logic signed [15:0]  in_m21,
  input  logic signed [15:0]  in_m22,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_quat_w,
  output logic signed [15:0]  out_quat_x,
  output logic signed [15:0]  out_quat_y,
  output logic signed [15:0]  out_quat_z
);
  import rmq_pkg::*;

  localparam logic signed [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;

  logic en;
  logic skid_valid_r;
  logic out_valid_r;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // front stage: trace combinations and sign tests
  logic signed [TW-1:0] e00, e11, e22;
  logic signed [TW-1:0] t [LANES];
  logic signed [16:0]   dsum [6];

  assign e00 = TW'(in_m00);
  assign e11 = TW'(in_m11);
  assign e22 = TW'(in_m22);
  assign t[0] = ONE_T + e00 + e11 + e22;
  assign t[1] = ONE_T + e00 - e11 - e22;
  assign t[2] = ONE_T - e00 + e11 - e22;
  assign t[3] = ONE_T - e00 - e11 + e22;

  assign dsum[0] = 17'(in_m21) - 17'(in_m12);
  assign dsum[1] = 17'(in_m02) - 17'(in_m20);
  assign dsum[2] = 17'(in_m10) - 17'(in_m01);
  assign dsum[3] = 17'(in_m10) + 17'(in_m01);
  assign dsum[4] = 17'(in_m02) + 17'(in_m20);
  assign dsum[5] = 17'(in_m21) + 17'(in_m12);

  logic       a_valid_r;
  rmq_u_t     a_u_r  [LANES];
  logic [5:0] a_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        a_u_r[l] <= t[l][TW-1] ? '0 : t[l][UW-1:0];
      end
      for (int k = 0; k < 6; k++) begin
        a_neg_r[k] <= dsum[k][16];
      end
    end
  end

  // pick the largest component, first wins on a tie, and derive signs
  rmq_tag_t root_tag;

  always_comb begin
    root_tag.valid = a_valid_r;
    if (a_u_r[0] >= a_u_r[1] && a_u_r[0] >= a_u_r[2] && a_u_r[0] >= a_u_r[3]) begin
      root_tag.neg = {a_neg_r[2], a_neg_r[1], a_neg_r[0], 1'b0};
    end else if (a_u_r[1] >= a_u_r[2] && a_u_r[1] >= a_u_r[3]) begin
      root_tag.neg = {a_neg_r[4], a_neg_r[3], 1'b0, a_neg_r[0]};
    end else if (a_u_r[2] >= a_u_r[3]) begin
      root_tag.neg = {a_neg_r[5], 1'b0, a_neg_r[3], a_neg_r[1]};
    end else begin
      root_tag.neg = {1'b0, a_neg_r[5], a_neg_r[4], a_neg_r[2]};
    end
  end

  rmq_tag_t s_tag;
  rmq_s_t   s_val [LANES];

  rmq_root4 u_root4 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (root_tag),
    .u_i   (a_u_r),
    .tag_o (s_tag),
    .s_o   (s_val)
  );

  logic   tail_valid;
  rmq_q_t tail_q [LANES];

  rmq_norm_div u_norm_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_i   (s_tag),
    .s_i     (s_val),
    .valid_o (tail_valid),
    .q_o     (tail_q)
  );

  // output register plus skid register
  rmq_q_t out_q_r  [LANES];
  rmq_q_t skid_q_r [LANES];
  logic   take_out;
  logic   take_skid;
  logic   drain_skid;

  assign take_out   = en && (!out_valid_r || !out_stall);
  assign take_skid  = en && out_valid_r && out_stall && tail_valid;
  assign drain_skid = skid_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (take_out) begin
        out_valid_r <= tail_valid;
      end
      if (take_skid) begin
        skid_valid_r <= 1'b1;
      end else if (drain_skid) begin
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      out_q_r <= tail_q;
    end else if (drain_skid) begin
      out_q_r <= skid_q_r;
    end
    if (take_skid) begin
      skid_q_r <= tail_q;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_quat_w = out_q_r[0];
  assign out_quat_x = out_q_r[1];
  assign out_quat_y = out_q_r[2];
  assign out_quat_z = out_q_r[3];

endmodule

>>> sim/rmq_checker.sv
// Checker for the matrix-to-quaternion block: predicts each quaternion and compares.
`timescale 1ns / 1ps
module rmq_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_m00, in_m01, in_m02,
  input  logic signed [15:0] in_m10, in_m11, in_m12,
  input  logic signed [15:0] in_m20, in_m21, in_m22,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z,
  output int                 fail_count,
  output int                 pending
);
  import rmq_pkg::*;

  localparam int EXP_DEPTH = 256;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  // expected items in order of acceptance
  quat_t quat_expected [EXP_DEPTH];
  int    wr_cnt;
  int    rd_cnt;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int sign_of(longint d);
    return (d >= 0) ? 1 : -1;
  endfunction

  function automatic quat_t predict_quat(longint a00, a01, a02, a10, a11, a12,
                                         a20, a21, a22);
    longint one, t[4], v;
    longint unsigned u[4], s[4], sum, n, q;
    int sg[4];
    logic [15:0] f[4];
    quat_t r;
    one = 64'sd1 <<< FRAC_BITS;
    t[0] = one + a00 + a11 + a22;
    t[1] = one + a00 - a11 - a22;
    t[2] = one - a00 + a11 - a22;
    t[3] = one - a00 - a11 + a22;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      u[i] = (t[i] < 0) ? 0 : t[i];
      s[i] = int_root(u[i] << FRAC_BITS);
      sum += s[i] * s[i];
    end
    if (u[0] >= u[1] && u[0] >= u[2] && u[0] >= u[3]) begin
      sg = '{1, sign_of(a21 - a12), sign_of(a02 - a20), sign_of(a10 - a01)};
    end else if (u[1] >= u[2] && u[1] >= u[3]) begin
      sg = '{sign_of(a21 - a12), 1, sign_of(a10 + a01), sign_of(a02 + a20)};
    end else if (u[2] >= u[3]) begin
      sg = '{sign_of(a02 - a20), sign_of(a10 + a01), 1, sign_of(a21 + a12)};
    end else begin
      sg = '{sign_of(a10 - a01), sign_of(a20 + a02), sign_of(a21 + a12), 1};
    end
    n = int_root(sum);
    for (int i = 0; i < 4; i++) begin
      if (n == 0) q = (i == 0) ? one : 0;
      else q = ((s[i] << FRAC_BITS) + (n >> 1)) / n;
      if (q > one) q = one;
      v = q;
      if (sg[i] < 0) v = -v;
      f[i] = v[15:0];
    end
    r.w = f[0]; r.x = f[1]; r.y = f[2]; r.z = f[3];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t quaternion %s mismatch: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    wr_cnt = 0;
    rd_cnt = 0;
  end
  assign pending = wr_cnt - rd_cnt;

  always @(posedge clk) begin
    quat_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        quat_expected[wr_cnt % EXP_DEPTH] = predict_quat(in_m00, in_m01, in_m02,
                                                         in_m10, in_m11, in_m12,
                                                         in_m20, in_m21, in_m22);
        wr_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (wr_cnt == rd_cnt) begin
          report_mismatch("unexpected item", out_quat_w, 0);
        end else begin
          e = quat_expected[rd_cnt % EXP_DEPTH];
          rd_cnt++;
          if (out_quat_w !== e.w) report_mismatch("w", out_quat_w, e.w);
          if (out_quat_x !== e.x) report_mismatch("x", out_quat_x, e.x);
          if (out_quat_y !== e.y) report_mismatch("y", out_quat_y, e.y);
          if (out_quat_z !== e.z) report_mismatch("z", out_quat_z, e.z);
        end
      end
    end
  end
endmodule

>>> sim/tb_rotation_matrix_to_quaternion.sv
// Testbench top: drives matrices, throttles the output and gives the verdict.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion;
  localparam int ONE = 16384;
  localparam logic signed [15:0] ONE_M = 16'sd16384;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] m[9];
  logic signed [15:0] qw, qx, qy, qz;
  int fail_count, pending, send_idle, recv_idle, idle_cycles;

  rotation_matrix_to_quaternion DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_m00(m[0]), .in_m01(m[1]), .in_m02(m[2]), .in_m10(m[3]), .in_m11(m[4]),
    .in_m12(m[5]), .in_m20(m[6]), .in_m21(m[7]), .in_m22(m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_quat_w(qw), .out_quat_x(qx), .out_quat_y(qy), .out_quat_z(qz)
  );

  rmq_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_m00(m[0]), .in_m01(m[1]), .in_m02(m[2]), .in_m10(m[3]), .in_m11(m[4]),
    .in_m12(m[5]), .in_m20(m[6]), .in_m21(m[7]), .in_m22(m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_quat_w(qw), .out_quat_x(qx), .out_quat_y(qy), .out_quat_z(qz),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver throttle
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  // watchdog: cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("rotation_matrix_to_quaternion regression: fail");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(5))
      0: return -ONE_M;
      1: return ONE_M;
      2: return 0;
      3: return 16'($urandom());
      default: return 16'($signed($urandom_range(2 * ONE)) - ONE);
    endcase
  endfunction

  // send one matrix; row-major, held until accepted
  task automatic send_matrix(input logic signed [15:0] a[9]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) m[i] <= a[i];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // rotation by a random angle about one axis with exact extremes mixed in
  task automatic send_rotation();
    logic signed [15:0] a[9];
    int ax;
    logic signed [15:0] c, s;
    ax = $urandom_range(2);
    c = 16'($signed($urandom_range(2 * ONE)) - ONE);
    s = 16'($urandom_range(1) ? $rtoi($sqrt(real'(ONE) * ONE - real'(c) * c))
                              : -$rtoi($sqrt(real'(ONE) * ONE - real'(c) * c)));
    a = '{default: 0};
    a[ax * 4] = ONE_M;
    case (ax)
      0: a = '{ONE_M, 0, 0, 0, c, -s, 0, s, c};
      1: a = '{c, 0, s, 0, ONE_M, 0, -s, 0, c};
      default: a = '{c, -s, 0, s, c, 0, 0, 0, ONE_M};
    endcase
    send_matrix(a);
  endtask

  initial begin
    logic signed [15:0] a[9];
    in_valid = 1'b0;
    out_stall = 1'b0;
    idle_cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 9; i++) m[i] = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity, half turns, zero, extremes, ties, all-bits patterns
    send_matrix('{ONE_M, 0, 0, 0, ONE_M, 0, 0, 0, ONE_M});
    send_matrix('{ONE_M, 0, 0, 0, -ONE_M, 0, 0, 0, -ONE_M});
    send_matrix('{-ONE_M, 0, 0, 0, ONE_M, 0, 0, 0, -ONE_M});
    send_matrix('{-ONE_M, 0, 0, 0, -ONE_M, 0, 0, 0, ONE_M});
    send_matrix('{default: 0});
    send_matrix('{default: ONE_M});
    send_matrix('{default: -ONE_M});
    send_matrix('{default: 16'sh7fff});
    send_matrix('{default: 16'sh8000});
    send_matrix('{default: 16'shffff});
    send_matrix('{-ONE_M, 0, 0, 0, -ONE_M, 0, 0, 0, -ONE_M});
    send_matrix('{0, -ONE_M, 0, ONE_M, 0, 0, 0, 0, ONE_M});
    send_matrix('{0, ONE_M, 0, ONE_M, 0, 0, 0, 0, -ONE_M});
    send_matrix('{0, 5, -5, 5, 0, 7, -5, 7, 0});
    send_matrix('{ONE_M, 3, -3, -3, ONE_M, 3, 3, -3, ONE_M});
    send_matrix('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
                  16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555});

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 32 : (ph == 1) ? 86 : 0;
      recv_idle = (ph == 0) ? 86 : (ph == 1) ? 32 : 0;
      for (int k = 0; k < 300; k++) begin
        if ($urandom_range(99) < 70) begin
          send_rotation();
        end else begin
          for (int i = 0; i < 9; i++) a[i] = rand_elem();
          send_matrix(a);
        end
        if (ph == 2 && k == 150) begin
          // hold input until the pipeline is empty
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    recv_idle = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("rotation_matrix_to_quaternion regression: pass");
    else $display("rotation_matrix_to_quaternion regression: fail");
    $finish;
  end
endmodule
